### rtl/dsw_pkg.sv
package dsw_pkg;

    localparam int VALUE_W    = 27;
    localparam int MAX_DIGITS = 8;
    localparam int MIN_DIGITS = 3;
    localparam int DP_POS     = 3;
    localparam int BCD_W      = MAX_DIGITS * 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [VALUE_W-1:0] SAT_VALUE       = VALUE_W'(10 ** MAX_DIGITS - 1);
    localparam logic [ADDR_W-1:0]  SCAN_LIMIT_ADDR = 4'd11;
    localparam logic [DATA_W-1:0]  DP_BIT          = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // converter result handed to the write sequencer
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

    function automatic logic [DATA_W-1:0] seg_code(input logic [3:0] digit);
        logic [DATA_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### rtl/decimal_seven_segment_writer_core.sv
// writes: the scan limit write is the first on the ports; the other writes
//   follow one a cycle, n + 1 writes in all (n digits shown, 3..8)
// flow: a new item is taken only once the last write of the previous one is registered;
//   conversion is a 27-step bit-serial binary to decimal conversion; results cannot be
//   stalled by the receiver
// reset: synchronous active low, returns to idle and drops busy and the strobe
module decimal_seven_segment_writer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [dsw_pkg::VALUE_W-1:0]  i_value,
    output logic                         busy,
    output logic                         o_strobe,
    output logic [dsw_pkg::ADDR_W-1:0]   o_reg_address,
    output logic [dsw_pkg::DATA_W-1:0]   o_reg_data,
    output logic                         o_last
);

    dsw_pkg::t_state             r_state;
    dsw_pkg::t_state             n_state;
    logic                        accept;
    logic                        emit_busy;
    logic [dsw_pkg::VALUE_W-1:0] sat_value;
    dsw_pkg::t_conv_res          conv_res;

    // an item is taken whenever the block is idle and start is high
    assign accept = start && !busy;

    // values beyond the display range clamp to all nines
    assign sat_value = (i_value > dsw_pkg::SAT_VALUE) ? dsw_pkg::SAT_VALUE : i_value;

    // shift-add-three converter, one input bit per cycle
    dsw_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (sat_value),
        .o_res   (conv_res)
    );

    // write sequencer: scan limit first, then one digit per cycle, lsd first
    dsw_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (conv_res),
        .o_busy        (emit_busy),
        .o_strobe      (o_strobe),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_last        (o_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // top-level sequencing: idle, converting, emitting writes
    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        unique case (r_state)
            dsw_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = dsw_pkg::ST_CONV;
                end
            end
            dsw_pkg::ST_CONV: begin
                // converter result loads straight into the sequencer
                if (conv_res.done) begin
                    n_state = dsw_pkg::ST_EMIT;
                end
            end
            dsw_pkg::ST_EMIT: begin
                // free once the final write is in the output register
                if (!emit_busy) begin
                    n_state = dsw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dsw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/dsw_dabble.sv
module dsw_dabble (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dsw_pkg::VALUE_W-1:0]  i_value,
    output dsw_pkg::t_conv_res           o_res
);

    logic [dsw_pkg::VALUE_W-1:0]   r_bin;
    logic [dsw_pkg::BCD_W-1:0]     r_bcd;
    logic [dsw_pkg::BIT_CNT_W-1:0] r_cnt;
    logic                          r_run;
    logic                          r_done;
    logic [dsw_pkg::BCD_W-1:0]     n_adj;

    // add three to every digit above four before the shift
    always_comb begin
        for (int d = 0; d < dsw_pkg::MAX_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] > 4'd4) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
            r_cnt <= dsw_pkg::BIT_CNT_W'(dsw_pkg::VALUE_W - 1);
        end else if (r_run) begin
            r_bcd <= {n_adj[dsw_pkg::BCD_W-2:0], r_bin[dsw_pkg::VALUE_W-1]};
            r_bin <= {r_bin[dsw_pkg::VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.bcd  = r_bcd;

endmodule

### rtl/dsw_emit.sv
module dsw_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dsw_pkg::t_conv_res           i_res,
    output logic                         o_busy,
    output logic                         o_strobe,
    output logic [dsw_pkg::ADDR_W-1:0]   o_reg_address,
    output logic [dsw_pkg::DATA_W-1:0]   o_reg_data,
    output logic                         o_last
);

    logic [dsw_pkg::BCD_W-1:0]     r_bcd;
    logic [dsw_pkg::DIG_CNT_W-1:0] r_idx;
    logic [dsw_pkg::DIG_CNT_W-1:0] r_ndig;
    logic                          r_run;
    logic                          r_strobe;
    logic [dsw_pkg::ADDR_W-1:0]    r_addr;
    logic [dsw_pkg::DATA_W-1:0]    r_data;
    logic                          r_last;
    logic [dsw_pkg::DIG_CNT_W-1:0] n_ndig;
    logic [dsw_pkg::DATA_W-1:0]    n_code;

    // highest non-zero digit, never fewer than the minimum shown
    always_comb begin
        n_ndig = dsw_pkg::DIG_CNT_W'(dsw_pkg::MIN_DIGITS);
        for (int d = dsw_pkg::MIN_DIGITS; d < dsw_pkg::MAX_DIGITS; d++) begin
            if (i_res.bcd[d*4 +: 4] != 4'd0) begin
                n_ndig = dsw_pkg::DIG_CNT_W'(d + 1);
            end
        end
    end

    always_comb begin
        n_code = dsw_pkg::seg_code(r_bcd[3:0]);
        if (r_idx == dsw_pkg::DIG_CNT_W'(dsw_pkg::DP_POS)) begin
            n_code = n_code | dsw_pkg::DP_BIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_run;
            if (i_res.done) begin
                r_run <= 1'b1;
            end else if (r_run && r_idx == r_ndig) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.done) begin
            r_bcd  <= i_res.bcd;
            r_ndig <= n_ndig;
            r_idx  <= '0;
        end else if (r_run) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == '0) begin
                r_addr <= dsw_pkg::SCAN_LIMIT_ADDR;
                r_data <= dsw_pkg::DATA_W'(r_ndig - 1'b1);
                r_last <= 1'b0;
            end else begin
                r_addr <= dsw_pkg::ADDR_W'(r_idx);
                r_data <= n_code;
                r_last <= (r_idx == r_ndig);
                r_bcd  <= {4'd0, r_bcd[dsw_pkg::BCD_W-1:4]};
            end
        end
    end

    assign o_busy        = r_run;
    assign o_strobe      = r_strobe;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_last        = r_last;

endmodule

### rtl/dsw_checker.sv
module dsw_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         o_strobe,
    input  logic [dsw_pkg::ADDR_W-1:0]   o_reg_address,
    input  logic                         o_last
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an item was accepted");

    // no write appears right after an item is accepted
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("write strobed just after acceptance");

    // the scan limit write is followed by digit one
    a_scan_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_reg_address == dsw_pkg::SCAN_LIMIT_ADDR)
        |=> (o_strobe && o_reg_address == dsw_pkg::ADDR_W'(1)))
        else $error("scan limit write not followed by first digit");

    // writes of one item are back to back until the flagged one
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a write sequence");

    // the flagged write ends the sequence
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("write strobed after the final write");

endmodule

bind decimal_seven_segment_writer_core dsw_checker u_dsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_reg_address (o_reg_address),
    .o_last        (o_last)
);

### tb/tb_decimal_seven_segment_writer_core.sv
module tb_decimal_seven_segment_writer_core;

    // one register write as the display driver sees it
    typedef struct {
        logic [dsw_pkg::ADDR_W-1:0] addr;
        logic [dsw_pkg::DATA_W-1:0] data;
        logic                       fin;
    } t_seg_write;

    // segment patterns for the decimal digits, bit 7 left clear
    localparam bit [dsw_pkg::DATA_W-1:0] GLYPH [0:9] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    // predicts the write sequence of each accepted value and checks the
    // strobed writes against it in order
    class seg_write_board;
        t_seg_write  expected_writes[$];
        int unsigned errors;
        int unsigned values_seen;
        int unsigned writes_seen;

        function void note_value(logic [dsw_pkg::VALUE_W-1:0] raw);
            int unsigned shown;
            int unsigned rest;
            int unsigned n_digits;
            int unsigned pos;
            t_seg_write  w;
            values_seen++;
            shown = raw;
            // anything past eight nines saturates to eight nines
            if (shown > dsw_pkg::SAT_VALUE)
                shown = dsw_pkg::SAT_VALUE;
            n_digits = 0;
            rest     = shown;
            do begin
                n_digits++;
                rest = rest / 10;
            end while (rest != 0);
            // pad small values with leading zeros, so zero shows as 0.00
            if (n_digits < dsw_pkg::MIN_DIGITS)
                n_digits = dsw_pkg::MIN_DIGITS;
            w.addr = dsw_pkg::SCAN_LIMIT_ADDR;
            w.data = dsw_pkg::DATA_W'(n_digits - 1);
            w.fin  = 1'b0;
            expected_writes.push_back(w);
            // digit writes, least significant position first
            rest = shown;
            for (pos = 1; pos <= n_digits; pos++) begin
                w.addr = dsw_pkg::ADDR_W'(pos);
                w.data = GLYPH[rest % 10];
                if (pos == dsw_pkg::DP_POS)
                    w.data = w.data | dsw_pkg::DP_BIT;
                w.fin  = (pos == n_digits);
                rest   = rest / 10;
                expected_writes.push_back(w);
            end
        endfunction

        function void check_write(logic [dsw_pkg::ADDR_W-1:0] addr,
                                  logic [dsw_pkg::DATA_W-1:0] data,
                                  logic fin);
            t_seg_write w;
            writes_seen++;
            if (expected_writes.size() == 0) begin
                $error("unexpected write: reg_address=%0d reg_data=%02h last=%0b",
                       addr, data, fin);
                errors++;
                return;
            end
            w = expected_writes.pop_front();
            if (addr !== w.addr) begin
                $error("reg_address: expected %0d, got %0d", w.addr, addr);
                errors++;
            end
            if (data !== w.data) begin
                $error("reg_data: expected %02h, got %02h", w.data, data);
                errors++;
            end
            if (fin !== w.fin) begin
                $error("last: expected %0b, got %0b", w.fin, fin);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_writes.size();
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic [dsw_pkg::VALUE_W-1:0] i_value;
    logic                        busy;
    logic                        o_strobe;
    logic [dsw_pkg::ADDR_W-1:0]  o_reg_address;
    logic [dsw_pkg::DATA_W-1:0]  o_reg_data;
    logic                        o_last;

    seg_write_board board = new();

    decimal_seven_segment_writer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_value       (i_value),
        .busy          (busy),
        .o_strobe      (o_strobe),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    // monitor: everything sampled at the edge, before the block's own updates land
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            board.note_value(i_value);
        if (i_rst_n && o_strobe)
            board.check_write(o_reg_address, o_reg_data, o_last);
    end

    // number of idle cycles before the next item, for a given idling percentage
    function automatic int idle_gap(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 40)
            n++;
        return n;
    endfunction

    // random value, mostly spread evenly over digit counts, now and then
    // the whole 27-bit range so the saturation path gets hit too
    function automatic logic [dsw_pkg::VALUE_W-1:0] pick_value();
        int unsigned n_dig;
        int unsigned lo;
        int unsigned hi;
        logic [31:0] raw;
        if ($urandom_range(99) < 15) begin
            raw = $urandom;
            return raw[dsw_pkg::VALUE_W-1:0];
        end
        n_dig = $urandom_range(dsw_pkg::MAX_DIGITS, 1);
        lo    = (n_dig == 1) ? 0 : 10 ** (n_dig - 1);
        hi    = 10 ** n_dig - 1;
        return dsw_pkg::VALUE_W'($urandom_range(hi, lo));
    endfunction

    // present one item and hold it until the block takes it; called at the
    // edge where the previous item went in, so start is only lowered for a gap
    task automatic drive_value(logic [dsw_pkg::VALUE_W-1:0] v, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_value <= dsw_pkg::VALUE_W'($urandom);
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= v;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    // hold the sender off until every predicted write has come out; the
    // monitor notes the last item at the same edge, so look after it has run
    task automatic drain_writes();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (board.pending() != 0);
        @(posedge i_clk);
    endtask

    logic [dsw_pkg::VALUE_W-1:0] corner_values[$];
    int                          idle_pct[4] = '{0, 77, 0, 34};
    int                          phase;
    int                          k;
    int                          wait_cycles;

    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero and small values needing padding, every digit-count
        // boundary, the decimal point position, all ten glyphs, and values
        // past eight nines up to the largest the field can carry
        corner_values = '{0, 1, 9, 10, 99, 100, 101, 999, 1000, 9999, 10000,
                          99999, 100000, 999999, 1000000, 9999999, 10000000,
                          12345678, 90876543, 99999999, 100000000, 123456789,
                          {dsw_pkg::VALUE_W{1'b1}}, 27'h5555555, 27'h2AAAAAA};
        foreach (corner_values[i])
            drive_value(corner_values[i], $urandom_range(1, 0));
        drain_writes();

        // random phases with different amounts of sender idling; the
        // receiver side cannot stall, so only the sender gaps vary
        for (phase = 0; phase < 4; phase++) begin
            for (k = 0; k < 101; k++)
                drive_value(pick_value(), idle_gap(idle_pct[phase]));
            if (phase == 1)
                drain_writes();
        end
        start <= 1'b0;

        // let the tail of the last sequence come out, then watch for strays
        wait_cycles = 0;
        do begin
            @(negedge i_clk);
            wait_cycles++;
        end while (board.pending() != 0 && wait_cycles < 2000);
        if (board.pending() != 0) begin
            $error("%0d writes never arrived", board.pending());
            board.errors++;
        end
        repeat (60) @(posedge i_clk);

        $display("covered %0d values (padding, every digit count, saturation) and %0d writes",
                 board.values_seen, board.writes_seen);
        $display("sender idling phases: none, heavy, none, moderate, with drains between");
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
